[hw/rtl/scene_stability_and_brightest_row_macros.svh]
// Assertion macros for the scene stability and brightest row block.
// Included by files that check their own logic; expects clk and rst in scope.
`ifndef SCENE_STABILITY_AND_BRIGHTEST_ROW_MACROS_SVH
`define SCENE_STABILITY_AND_BRIGHTEST_ROW_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define SSBR_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssbr check failed");
// Next-cycle implication, checked outside reset
`define SSBR_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssbr check failed");
`else
`define SSBR_CHECK_NOW(lbl, ante, cons)
`define SSBR_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/ssbr_pkg.sv]
// Shared types, constants and helpers for the scene stability block.
// No dependencies; every RTL module imports this package.
package ssbr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int DIFF_W     = 10;
  localparam int THR_W      = 10;
  localparam int CNT_W      = 21;
  localparam int RUN_W      = 8;
  localparam int PCT_W      = 7;
  localparam int POS_W      = 10;
  localparam int SUM_W      = 20;
  localparam int HGT_W      = 11;
  localparam int ROI_W      = 11;
  localparam int KIND_W     = 2;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // Counter limits: saturate at min(MAX, 1024) - 1
  localparam int ROW_CAP = (MAX_HEIGHT > 1024) ? 1024 : MAX_HEIGHT;
  localparam int COL_CAP = (MAX_WIDTH > 1024) ? 1024 : MAX_WIDTH;
  localparam logic [POS_W-1:0] ROW_LIM = POS_W'(ROW_CAP - 1);
  localparam logic [POS_W-1:0] COL_LIM = POS_W'(COL_CAP - 1);

  localparam logic [CNT_W-1:0] CHANGED_MAX = {CNT_W{1'b1}};
  localparam logic [RUN_W-1:0] RUN_MAX     = {RUN_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [ROI_W-1:0] ROI_MAX     = {ROI_W{1'b1}};

  // ROI offset is floor(height * percent / 400). With 400 = 16 * 25, drop four
  // bits, then floor(y / 25) = (y * 5243) >> 17 holds for every y below 43690.
  localparam int ROI_PRE_SHIFT   = 4;
  localparam int ROI_RECIP_W     = 13;
  localparam logic [ROI_RECIP_W-1:0] ROI_RECIP = ROI_RECIP_W'(5243);
  localparam int ROI_RECIP_SHIFT = 17;
  localparam int OFS_PROD_W      = SUM_W - ROI_PRE_SHIFT + ROI_RECIP_W;

  // Average divider
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COLUMN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROI     = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NEEDED    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERCENT   = 2'd3;

  // Configuration reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(50);
  localparam logic [CNT_W-1:0] LIMIT_RST     = CNT_W'(10);
  localparam logic [RUN_W-1:0] NEEDED_RST    = RUN_W'(5);
  localparam logic [PCT_W-1:0] PERCENT_RST   = PCT_W'(30);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] red_a;
    logic [PIX_W-1:0] green_a;
    logic [PIX_W-1:0] blue_a;
    logic [PIX_W-1:0] red_b;
    logic [PIX_W-1:0] green_b;
    logic [PIX_W-1:0] blue_b;
    logic             column_end;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  changed_pixels;
    logic [RUN_W-1:0]  stable_count;
    logic              stable_reached;
    logic [POS_W-1:0]  column_index;
    logic [POS_W-1:0]  brightest_row;
    logic [ROI_W-1:0]  roi_start;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [CNT_W-1:0] limit;
    logic [RUN_W-1:0] needed;
    logic [PCT_W-1:0] percent;
  } cfg_t;

  // Work item handed from front to back
  typedef struct packed {
    result_t          res;
    logic [SUM_W-1:0] row_sum;
    logic [HGT_W-1:0] cols;
    logic [HGT_W-1:0] height;
  } job_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[hw/rtl/ssbr_queue.sv]
// Short job queue between the front and back parts.
// Depends on ssbr_pkg for job_t and the queue depth.
module ssbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssbr_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output ssbr_pkg::job_t rdata,
  output logic          empty
);
  import ssbr_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

[hw/rtl/ssbr_front.sv]
// Front part: per-pixel change counting, stability run and column scan.
// Depends on ssbr_pkg; emits one job per frame end, and per column end while scanning.
module ssbr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  ssbr_pkg::pixel_t pixel,
  input  ssbr_pkg::cfg_t   cfg,
  output logic            job_push,
  output ssbr_pkg::job_t   job
);
  import ssbr_pkg::*;

  logic             scan_mode;
  logic [CNT_W-1:0] changed_count;
  logic [RUN_W-1:0] stable_frames;
  logic [POS_W-1:0] row_counter;
  logic [POS_W-1:0] column_counter;
  logic [PIX_W-1:0] column_best_value;
  logic [POS_W-1:0] column_best_row;
  logic [SUM_W-1:0] row_sum;

  logic [DIFF_W-1:0] diff;
  logic [CNT_W-1:0]  changed_next;
  logic [RUN_W-1:0]  stable_next;
  logic              reached;
  logic              col_done;
  logic              take_red;
  logic [PIX_W-1:0]  best_value_next;
  logic [POS_W-1:0]  best_row_next;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_next;

  // Waiting mode: summed RGB difference and frame verdict
  always_comb begin
    diff = DIFF_W'(abs_diff(pixel.red_a, pixel.red_b))
         + DIFF_W'(abs_diff(pixel.green_a, pixel.green_b))
         + DIFF_W'(abs_diff(pixel.blue_a, pixel.blue_b));
    changed_next = changed_count
                 + CNT_W'(diff > cfg.threshold && changed_count != CHANGED_MAX);
    if (changed_next < cfg.limit) begin
      stable_next = (stable_frames == RUN_MAX) ? RUN_MAX : stable_frames + 1'b1;
    end else begin
      stable_next = '0;
    end
    reached = (stable_next >= cfg.needed);
  end

  // Scan mode: track the first strictly brightest row of the column
  always_comb begin
    col_done        = pixel.column_end || pixel.frame_end;
    take_red        = pixel.red_a > column_best_value;
    best_value_next = take_red ? pixel.red_a : column_best_value;
    best_row_next   = take_red ? row_counter : column_best_row;
    sum_wide        = {1'b0, row_sum} + (SUM_W + 1)'(best_row_next);
    sum_next        = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  // Build the job for the back part
  always_comb begin
    job      = '0;
    job_push = accept && (scan_mode ? col_done : pixel.frame_end);
    if (!scan_mode) begin
      job.res.kind           = KIND_VERDICT;
      job.res.changed_pixels = changed_next;
      job.res.stable_count   = stable_next;
      job.res.stable_reached = reached;
    end else begin
      job.res.column_index  = column_counter;
      job.res.brightest_row = best_row_next;
      if (pixel.frame_end) begin
        job.res.kind = KIND_ROI;
        job.res.last = 1'b1;
        job.row_sum  = sum_next;
        job.cols     = {1'b0, column_counter} + 1'b1;
        job.height   = {1'b0, row_counter} + 1'b1;
      end else begin
        job.res.kind = KIND_COLUMN;
      end
    end
  end

  // Update state on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode         <= 1'b0;
      changed_count     <= '0;
      stable_frames     <= '0;
      row_counter       <= '0;
      column_counter    <= '0;
      column_best_value <= '0;
      column_best_row   <= '0;
      row_sum           <= '0;
    end else if (accept) begin
      if (!scan_mode) begin
        if (!pixel.frame_end) begin
          changed_count <= changed_next;
        end else begin
          changed_count <= '0;
          if (reached) begin
            stable_frames <= '0;
            scan_mode     <= 1'b1;
          end else begin
            stable_frames <= stable_next;
          end
        end
      end else if (!col_done) begin
        column_best_value <= best_value_next;
        column_best_row   <= best_row_next;
        if (row_counter < ROW_LIM) begin
          row_counter <= row_counter + 1'b1;
        end
      end else if (pixel.frame_end) begin
        // Scan done: drop back to waiting with everything cleared
        scan_mode         <= 1'b0;
        row_counter       <= '0;
        column_counter    <= '0;
        column_best_value <= '0;
        column_best_row   <= '0;
        row_sum           <= '0;
      end else begin
        row_sum           <= sum_next;
        row_counter       <= '0;
        column_best_value <= '0;
        column_best_row   <= '0;
        if (column_counter < COL_LIM) begin
          column_counter <= column_counter + 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/ssbr_back.sv]
// Back part: ROI average on a radix-2 divider, height offset by reciprocal
// multiply, and the output register. Depends on ssbr_pkg for job_t and result_t.
module ssbr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ssbr_pkg::PCT_W-1:0]  percent,
  input  logic                        job_avail,
  input  ssbr_pkg::job_t               job,
  output logic                        job_take,
  input  logic                        pop,
  output logic                        out_valid,
  output ssbr_pkg::result_t            result
);
  import ssbr_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_DIV_AVG = 2'd1;
  localparam logic [1:0] ST_DIV_OFS = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [HGT_W-1:0]  rem;
  logic [HGT_W-1:0]  divisor;
  logic [HGT_W-1:0]  height;
  logic [ROI_W-1:0]  avg;
  result_t           pend;

  logic              slot_free;
  logic              load;
  logic [HGT_W:0]    partial;
  logic              ge;
  logic [HGT_W-1:0]  rem_next;
  logic [SUM_W-1:0]  quo_next;
  logic [OFS_PROD_W-1:0] ofs_prod;
  logic [SUM_W-1:0]  ofs;
  logic [SUM_W:0]    roi_wide;

  assign slot_free = !out_valid || pop;
  assign job_take  = (state == ST_IDLE) && job_avail && slot_free;
  assign load      = (job_take && job.res.kind != KIND_ROI)
                  || (state == ST_EMIT && slot_free);

  // One restoring division step; offset from the held height product
  always_comb begin
    partial  = {rem, quo[SUM_W-1]};
    ge       = partial >= {1'b0, divisor};
    rem_next = ge ? HGT_W'(partial - {1'b0, divisor}) : partial[HGT_W-1:0];
    quo_next = {quo[SUM_W-2:0], ge};
    ofs_prod = OFS_PROD_W'(quo[SUM_W-1:ROI_PRE_SHIFT]) * OFS_PROD_W'(ROI_RECIP);
    ofs      = SUM_W'(ofs_prod >> ROI_RECIP_SHIFT);
    roi_wide = (SUM_W + 1)'(avg) + (SUM_W + 1)'(ofs);
  end

  // Sequence the average division and the offset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_take && job.res.kind == KIND_ROI) begin
            pend    <= job.res;
            quo     <= job.row_sum;
            rem     <= '0;
            divisor <= job.cols;
            height  <= job.height;
            step    <= '0;
            state   <= ST_DIV_AVG;
          end
        end
        ST_DIV_AVG: begin
          quo  <= quo_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            // Average done: hold it and the height product for the offset
            avg     <= (|quo_next[SUM_W-1:ROI_W]) ? ROI_MAX : quo_next[ROI_W-1:0];
            quo     <= SUM_W'(height) * SUM_W'(percent);
            step    <= '0;
            state   <= ST_DIV_OFS;
          end
        end
        ST_DIV_OFS: begin
          pend.roi_start <= (|roi_wide[SUM_W:ROI_W]) ? ROI_MAX : roi_wide[ROI_W-1:0];
          state          <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the oldest result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= (state == ST_EMIT) ? pend : job.res;
    end
  end

endmodule

[hw/rtl/scene_stability_and_brightest_row.sv]
// Top level of the scene stability and brightest row block.
// Depends on ssbr_pkg, ssbr_front, ssbr_queue, ssbr_back and the macro header.
//
//   channel   handshake             payload
//   pixel     push / full           ssbr_pkg::pixel_t  pixel
//   result    pop / empty           ssbr_pkg::result_t result
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel pair is taken per cycle while full is low. Verdict and column
// words pass through the job queue and the back part's output register before
// they can be popped; the ROI word also needs a 20-step pass through the back
// part's divider for the average, then the offset state and the output load.
// full rises only when the four-word job queue fills, i.e. when results are
// not popped or an ROI division is in flight. Synchronous reset clears all
// counters and restores the register defaults.
`include "scene_stability_and_brightest_row_macros.svh"

module scene_stability_and_brightest_row (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  ssbr_pkg::pixel_t                   pixel,
  output logic                              empty,
  input  logic                              pop,
  output ssbr_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssbr_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [ssbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssbr_pkg::*;

  cfg_t cfg;
  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic q_full;
  logic q_empty;
  logic job_take;
  logic out_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign empty     = !out_valid;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RST;
      cfg.limit     <= LIMIT_RST;
      cfg.needed    <= NEEDED_RST;
      cfg.percent   <= PERCENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        REG_LIMIT:     cfg.limit     <= cfg_data[CNT_W-1:0];
        REG_NEEDED:    cfg.needed    <= cfg_data[RUN_W-1:0];
        REG_PERCENT:   cfg.percent   <= cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssbr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel    (pixel),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (job_in)
  );

  ssbr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (q_full),
    .pop   (job_take),
    .rdata (job_out),
    .empty (q_empty)
  );

  ssbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .percent   (cfg.percent),
    .job_avail (!q_empty),
    .job       (job_out),
    .job_take  (job_take),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  // Only the ROI word closes a scan
  `SSBR_CHECK_NOW(a_roi_last, !empty && result.kind == KIND_ROI, result.last)
  `SSBR_CHECK_NOW(a_other_not_last, !empty && result.kind != KIND_ROI, !result.last)
  // The front never pushes a job into a full queue
  `SSBR_CHECK_NOW(a_no_overflow, job_push, !q_full)
  // A waiting word holds until popped
  `SSBR_CHECK_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(result))

endmodule

[dv/ssbr_checker.sv]
`timescale 1ns / 100ps
// Result checker for the scene stability and brightest row block: predicts every
// result word from accepted pixel and register words and compares them in order.
// Depends on ssbr_pkg for the word types, result kinds and register indexes.
module ssbr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  ssbr_pkg::pixel_t                pixel,
  input  logic                            empty,
  input  logic                            pop,
  input  ssbr_pkg::result_t               result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ssbr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ssbr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import ssbr_pkg::*;

  localparam int MAX_REPORTS = 10;
  // ROI offset is height * percent / 400
  localparam int ROI_SHARE_DIVISOR = 400;

  // Register copies
  logic [THR_W-1:0] threshold;
  logic [CNT_W-1:0] changed_limit;
  logic [RUN_W-1:0] frames_needed;
  logic [PCT_W-1:0] percent;

  // Scene state
  logic             scanning;
  logic [CNT_W-1:0] changed_cnt;
  logic [RUN_W-1:0] stable_run;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic [PIX_W-1:0] best_red;
  logic [POS_W-1:0] best_row;
  logic [SUM_W-1:0] row_total;

  result_t expected_words[$];
  int failures = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int channel_gap(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    channel_gap = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic clear_scene();
    scanning = 1'b0;
    changed_cnt = '0;
    stable_run = '0;
    row_pos = '0;
    col_pos = '0;
    best_red = '0;
    best_row = '0;
    row_total = '0;
  endtask

  // Advance the scene state by one pixel pair and queue any word it yields
  task automatic advance_scene(input pixel_t px);
    result_t w;
    int gap;
    int total;
    int height;
    int roi;
    w = '0;
    if (!scanning) begin
      gap = channel_gap(px.red_a, px.red_b) + channel_gap(px.green_a, px.green_b) +
            channel_gap(px.blue_a, px.blue_b);
      if (gap > int'(threshold) && changed_cnt != CHANGED_MAX) changed_cnt++;
      if (px.frame_end) begin
        if (changed_cnt < changed_limit) begin
          if (stable_run != RUN_MAX) stable_run++;
        end else begin
          stable_run = '0;
        end
        w.kind = KIND_VERDICT;
        w.changed_pixels = changed_cnt;
        w.stable_count = stable_run;
        changed_cnt = '0;
        if (stable_run >= frames_needed) begin
          w.stable_reached = 1'b1;
          clear_scene();
          scanning = 1'b1;
        end
        expected_words.push_back(w);
      end
    end else begin
      // Keep the first row of the strictly brightest red
      if (px.red_a > best_red) begin
        best_red = px.red_a;
        best_row = row_pos;
      end
      if (!px.column_end && !px.frame_end) begin
        if (row_pos != ROW_LIM) row_pos++;
      end else begin
        height = int'(row_pos) + 1;
        total = int'(row_total) + int'(best_row);
        row_total = (total > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
        w.column_index = col_pos;
        w.brightest_row = best_row;
        if (px.frame_end) begin
          roi = int'(row_total) / (int'(col_pos) + 1) +
                (height * int'(percent)) / ROI_SHARE_DIVISOR;
          w.kind = KIND_ROI;
          w.roi_start = (roi > int'(ROI_MAX)) ? ROI_MAX : ROI_W'(roi);
          w.last = 1'b1;
          clear_scene();
        end else begin
          w.kind = KIND_COLUMN;
          if (col_pos != COL_LIM) col_pos++;
          row_pos = '0;
          best_red = '0;
          best_row = '0;
        end
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic show_word(input string tag, input result_t w);
    $display("  %s: kind=%0d changed=%0d run=%0d reached=%0d col=%0d row=%0d roi=%0d last=%0d",
             tag, w.kind, w.changed_pixels, w.stable_count, w.stable_reached,
             w.column_index, w.brightest_row, w.roi_start, w.last);
  endtask

  // Compare a popped word with the oldest prediction
  task automatic check_word(input result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("[%0t] result word with nothing predicted", $realtime);
        show_word("actual", got);
      end
    end else begin
      want = expected_words.pop_front();
      if (got.kind !== want.kind || got.changed_pixels !== want.changed_pixels ||
          got.stable_count !== want.stable_count ||
          got.stable_reached !== want.stable_reached ||
          got.column_index !== want.column_index ||
          got.brightest_row !== want.brightest_row ||
          got.roi_start !== want.roi_start || got.last !== want.last) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("[%0t] result word mismatch", $realtime);
          show_word("expected", want);
          show_word("actual", got);
        end
      end
    end
  endtask

  // Watch all three channels; check pops before taking new pixels
  always @(posedge clk) begin
    if (rst) begin
      threshold = THRESHOLD_RST;
      changed_limit = LIMIT_RST;
      frames_needed = NEEDED_RST;
      percent = PERCENT_RST;
      clear_scene();
      expected_words.delete();
    end else begin
      if (pop && !empty) check_word(result);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          REG_LIMIT:     changed_limit = cfg_data[CNT_W-1:0];
          REG_NEEDED:    frames_needed = cfg_data[RUN_W-1:0];
          REG_PERCENT:   percent = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) advance_scene(pixel);
    end
    pending <= expected_words.size();
    fail_count <= failures;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the testbench for scene_stability_and_brightest_row: drives pixel frames,
// register writes and result pops with random idling, and gives the verdict.
// Depends on ssbr_pkg, the block itself and ssbr_checker.
module testbench;
  import ssbr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_PIXELS  = 90;

  typedef enum int {FRAME_QUIET, FRAME_CALM, FRAME_BUSY, FRAME_RAMP} frame_style_e;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  pixel_t                pixel = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int flag_noise_pct = 0;
  int pixels_sent = 0;
  int quiet_cycles = 0;

  scene_stability_and_brightest_row DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .pixel(pixel),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ssbr_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .pixel(pixel),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic pixel_t pixel_of(input int ra, input int ga, input int ba,
                                      input int rb, input int gb, input int bb,
                                      input bit ce, input bit fe);
    pixel_t px;
    px.red_a = PIX_W'(ra);
    px.green_a = PIX_W'(ga);
    px.blue_a = PIX_W'(ba);
    px.red_b = PIX_W'(rb);
    px.green_b = PIX_W'(gb);
    px.blue_b = PIX_W'(bb);
    px.column_end = ce;
    px.frame_end = fe;
    return px;
  endfunction

  // Red values bunched at the ends so ties and dark columns show up
  function automatic logic [PIX_W-1:0] pick_red();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] v);
    int n;
    n = int'(v) + int'($urandom_range(4)) - 2;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return PIX_W'(n);
  endfunction

  // Hold push high until the word is taken; idle before it at random
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all four registers; bits above each field carry random junk
  task automatic configure(input int thr, input int lim, input int need, input int pct);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[THR_W-1:0] = THR_W'(thr);
    put_reg(REG_THRESHOLD, d);
    d = CFG_DATA_W'(lim);
    put_reg(REG_LIMIT, d);
    d = CFG_DATA_W'($urandom);
    d[RUN_W-1:0] = RUN_W'(need);
    put_reg(REG_NEEDED, d);
    d = CFG_DATA_W'($urandom);
    d[PCT_W-1:0] = PCT_W'(pct);
    put_reg(REG_PERCENT, d);
    cfg_valid <= 1'b0;
  endtask

  // Drop push, wait for all predicted words, then let the ROI divider finish
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Send one frame in column order
  task automatic send_frame(input int cols, input int rows, input frame_style_e style);
    pixel_t px;
    for (int c = 0; c < cols; c++) begin
      for (int r = 0; r < rows; r++) begin
        px.red_a = (style == FRAME_RAMP) ? PIX_W'((r * 255) / ((rows > 1) ? rows - 1 : 1))
                                         : pick_red();
        px.green_a = PIX_W'($urandom);
        px.blue_a = PIX_W'($urandom);
        case (style)
          FRAME_QUIET: begin
            px.red_b = px.red_a;
            px.green_b = px.green_a;
            px.blue_b = px.blue_a;
          end
          FRAME_CALM: begin
            px.red_b = nudge(px.red_a);
            px.green_b = nudge(px.green_a);
            px.blue_b = nudge(px.blue_a);
          end
          default: begin
            px.red_b = PIX_W'($urandom);
            px.green_b = PIX_W'($urandom);
            px.blue_b = PIX_W'($urandom);
          end
        endcase
        px.column_end = (r == rows - 1);
        if ($urandom_range(99) < flag_noise_pct) px.column_end = ~px.column_end;
        px.frame_end = (c == cols - 1) && (r == rows - 1);
        if (px.frame_end) px.column_end = $urandom_range(1);
        else if ($urandom_range(199) < flag_noise_pct) px.frame_end = 1'b1;
        send_pixel(px);
      end
    end
  endtask

  // Random register setting, then random frames until enough pixels went in
  task automatic random_phase(input int idle, input int stall);
    int target;
    int cols;
    int rows;
    int pick;
    frame_style_e style;
    settle();
    configure(($urandom_range(3) == 0) ? $urandom_range(765) : $urandom_range(60),
              ($urandom_range(5) == 0) ? $urandom_range(1) * int'(CHANGED_MAX)
                                       : $urandom_range(1, 12),
              ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 3),
              ($urandom_range(5) == 0) ? 127 : $urandom_range(100));
    idle_pct = idle;
    stall_pct = stall;
    flag_noise_pct = 8;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      if ($urandom_range(9) == 0) begin
        cols = $urandom_range(6, 12);
        rows = $urandom_range(8, 20);
      end else begin
        cols = $urandom_range(1, 5);
        rows = $urandom_range(1, 6);
      end
      pick = $urandom_range(99);
      style = (pick < 40) ? FRAME_QUIET : (pick < 80) ? FRAME_CALM : FRAME_BUSY;
      send_frame(cols, rows, style);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: walk five short frames into scan mode
    send_pixel(pixel_of(255, 255, 255, 0, 0, 0, 1, 0));
    send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 0, 1));
    send_pixel(pixel_of(20, 10, 0, 0, 30, 10, 0, 1));
    send_pixel(pixel_of(0, 0, 0, 17, 17, 17, 0, 1));
    send_pixel(pixel_of(128, 128, 128, 128, 128, 128, 1, 1));
    send_pixel(pixel_of(0, 255, 0, 0, 255, 0, 0, 1));
    // Scan: dark column, tie on red, bright top ending the frame without column end
    send_pixel(pixel_of(0, 255, 255, 255, 255, 255, 0, 0));
    send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(pixel_of(0, 255, 0, 255, 0, 255, 1, 0));
    send_pixel(pixel_of(5, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(pixel_of(9, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(pixel_of(9, 0, 0, 0, 0, 0, 1, 0));
    send_pixel(pixel_of(255, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(pixel_of(255, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 0, 1));

    // Threshold at the largest difference, zero limit and zero run needed: every waiting frame starts a scan
    settle();
    configure(765, 0, 0, 0);
    idle_pct = 13;
    stall_pct = 13;
    send_frame(2, 2, FRAME_CALM);
    send_frame(40, 1, FRAME_BUSY);
    send_pixel(pixel_of(255, 0, 255, 0, 255, 0, 0, 1));
    send_frame(3, 4, FRAME_BUSY);

    // Zero threshold, top limit and a long run; then one tall ramp column
    settle();
    configure(0, int'(CHANGED_MAX), 40, 127);
    idle_pct = 57;
    stall_pct = 0;
    repeat (40) send_frame(1, 1, FRAME_BUSY);
    send_frame(1, 30, FRAME_RAMP);

    random_phase(0, 0);
    random_phase(57, 0);
    random_phase(0, 57);
    random_phase(13, 13);

    idle_pct = 0;
    stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
